// ===== src/mhpq_pkg.sv =====
`default_nettype none

package mhpq_pkg;

  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned LVL_W    = 4;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_WALK,
    ST_ROOT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]         payload;
  } entry_t;

  typedef struct packed {
    entry_t hi;
    entry_t lo;
  } pair_t;

  typedef struct packed {
    op_e              mode;
    logic [POS_W-1:0] bound;
    logic [POS_W-1:0] tgt1;
    logic [LVL_W-1:0] dlev;
  } op_t;

  typedef struct packed {
    logic             valid;
    logic             placed;
    logic [POS_W-1:0] pos;
    entry_t           carry;
  } tok_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
  } rd_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    entry_t           data;
  } wb_t;

endpackage

`default_nettype wire

// ===== src/mhpq_cell.sv =====
`default_nettype none

module mhpq_cell
  import mhpq_pkg::*;
#(
  parameter int unsigned LEVEL        = 0,
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire op_t   op_i,
  input  wire tok_t  tok_i,
  input  wire rd_t   rd_i,
  input  wire wb_t   wb_i,
  output tok_t       tok_o,
  output rd_t        rd_o,
  output wb_t        wb_o,
  output pair_t      rdata_o,
  output logic       done_o
);

  localparam int unsigned FIRST      = (1 << LEVEL) - 1;
  localparam int unsigned SPAN       = 1 << LEVEL;
  localparam int unsigned NEXT_FIRST = 2 * SPAN - 1;
  localparam int unsigned SIZE       = ((CAPACITY - FIRST) < SPAN) ? (CAPACITY - FIRST) : SPAN;
  localparam int unsigned ROWS       = (SIZE + 1) / 2;
  localparam int unsigned RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IW         = POS_W + 2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
  } store_t;

  store_t mem_lo [ROWS];
  store_t mem_hi [ROWS];
  store_t rd_lo_q, rd_hi_q;

  tok_t tok_q, tok_d;

  entry_t e_lo, e_hi, cur, best;
  logic   own_we;
  logic [POS_W-1:0] own_pos;
  entry_t own_data;

  logic   we;
  logic [POS_W-1:0] w_pos;
  entry_t w_ent;
  store_t w_data;
  logic [RW-1:0] w_row, r_row;

  logic [IW-1:0] left_g, grand_g;
  logic [POS_W-1:0] c_pos;
  logic has_l, has_r, sel, path_bit;

  assign e_lo = '{prio: rd_lo_q.prio, payload: PAY_W'(rd_lo_q.payload)};
  assign e_hi = '{prio: rd_hi_q.prio, payload: PAY_W'(rd_hi_q.payload)};
  assign rdata_o = '{hi: e_hi, lo: e_lo};

  always_comb begin
    tok_d    = '0;
    rd_o     = '0;
    wb_o     = '0;
    own_we   = 1'b0;
    own_pos  = '0;
    own_data = '0;
    done_o   = 1'b0;

    cur      = tok_i.pos[0] ? e_hi : e_lo;
    path_bit = op_i.tgt1[op_i.dlev - LVL_W'(LEVEL) - LVL_W'(1)];

    left_g = IW'(FIRST) + IW'({tok_i.pos, 1'b0});
    has_l  = left_g < IW'(op_i.bound);
    has_r  = (left_g + IW'(1)) < IW'(op_i.bound);
    sel    = has_r && (e_hi.prio > e_lo.prio);
    best   = sel ? e_hi : e_lo;
    c_pos  = {tok_i.pos[POS_W-2:0], sel};
    grand_g = IW'(NEXT_FIRST) + IW'({c_pos, 1'b0});

    if (tok_i.valid) begin
      case (op_i.mode)
        OP_PUSH: begin
          if (op_i.dlev == LVL_W'(LEVEL)) begin
            own_we   = 1'b1;
            own_pos  = tok_i.pos;
            own_data = tok_i.carry;
            done_o   = 1'b1;
          end else begin
            tok_d.valid = 1'b1;
            tok_d.pos   = {tok_i.pos[POS_W-2:0], path_bit};
            rd_o.valid  = 1'b1;
            rd_o.row    = tok_i.pos;
            if (tok_i.placed || (tok_i.carry.prio > cur.prio)) begin
              own_we       = 1'b1;
              own_pos      = tok_i.pos;
              own_data     = tok_i.carry;
              tok_d.carry  = cur;
              tok_d.placed = 1'b1;
            end else begin
              tok_d.carry  = tok_i.carry;
              tok_d.placed = tok_i.placed;
            end
          end
        end
        OP_POP: begin
          wb_o.valid = 1'b1;
          wb_o.pos   = tok_i.pos;
          if (has_l && (best.prio > tok_i.carry.prio)) begin
            wb_o.data = best;
            if (grand_g < IW'(op_i.bound)) begin
              tok_d.valid = 1'b1;
              tok_d.pos   = c_pos;
              tok_d.carry = tok_i.carry;
              rd_o.valid  = 1'b1;
              rd_o.row    = c_pos;
            end else begin
              own_we   = 1'b1;
              own_pos  = c_pos;
              own_data = tok_i.carry;
              done_o   = 1'b1;
            end
          end else begin
            wb_o.data = tok_i.carry;
            done_o    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign we     = own_we | wb_i.valid;
  assign w_pos  = wb_i.valid ? wb_i.pos : own_pos;
  assign w_ent  = wb_i.valid ? wb_i.data : own_data;
  assign w_data = '{prio: w_ent.prio, payload: w_ent.payload[PAYLOAD_BITS-1:0]};
  assign w_row  = w_pos[RW:1];
  assign r_row  = rd_i.row[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      if (w_pos[0]) begin
        mem_hi[w_row] <= w_data;
      end else begin
        mem_lo[w_row] <= w_data;
      end
    end
    if (rd_i.valid) begin
      rd_lo_q <= mem_lo[r_row];
      rd_hi_q <= mem_hi[r_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== src/max_heap_priority_queue_top.sv =====
// Channel  Dir  Width         Contents
// s_axis   in   tdata 64      payload, prio ; tuser 1: cmd
// m_axis   out  tdata 72      top_payload, top_prio, count ; tuser 3: top_valid, status
//
// One request at a time; a push goes through prep, then the walk down to the depth of the new
// slot, then root and result. A pop adds a load step before the walk, which ends at the depth
// the moved entry settles in; a rejected request or a pop of the last entry goes straight to root
// and result (depth at most 6 for 64 entries). The token walks one level cell per cycle.
// Reset clears the count, the handshake state and the chain tokens; no memory sweep.
// A new request is taken while a previous result waits; m_axis stalls hold the result.

`default_nettype none

module max_heap_priority_queue_top
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] payload, [63:32] prio
  input  wire logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // [31:0] top_payload, [63:32] top_prio, [70:64] count
  output logic [2:0]       m_axis_tuser   // [0] top_valid, [2:1] status
);

  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned LW     = $clog2(LEVELS);

  function automatic logic [LW-1:0] top_bit(input logic [CW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  op_t     op_q;
  status_e status_q;
  entry_t  x_q;
  logic [LW-1:0] lastlvl_q;
  logic [CW-1:0] lastpos_q;
  tok_t inj_q, inj_d;
  logic m_valid_q;
  logic [71:0] m_tdata_q;
  logic [2:0]  m_tuser_q;

  rd_t ctl_rd;
  logic [LW-1:0] ctl_lvl;
  logic out_load, accept, full;
  op_e cmd;
  logic [CW-1:0] n_inc, pop_pos;
  logic [LW-1:0] pop_lvl;

  tok_t  tok_in  [LEVELS];
  tok_t  tok_out [LEVELS];
  rd_t   rd_in   [LEVELS];
  rd_t   rd_out  [LEVELS];
  wb_t   wb_in   [LEVELS];
  wb_t   wb_out  [LEVELS];
  pair_t rdata   [LEVELS];
  logic [LEVELS-1:0] done;
  logic [LEVELS-1:0] tok_vld;

  assign cmd    = op_e'(s_axis_tuser[0]);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = (count_q == CW'(CAPACITY));
  assign n_inc  = count_q + CW'(1);
  assign pop_lvl = top_bit(count_q);

  always_comb begin
    pop_pos = count_q;
    pop_pos[pop_lvl] = 1'b0;
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    if (k == 0) begin : g_first
      always_comb begin
        tok_in[k] = (inj_q.valid && op_q.mode == OP_PUSH) ? inj_q : '0;
        rd_in[k]  = (ctl_rd.valid && ctl_lvl == LW'(k)) ? ctl_rd : '0;
      end
    end else if (k == 1) begin : g_second
      always_comb begin
        tok_in[k] = (inj_q.valid && op_q.mode == OP_POP) ? inj_q : tok_out[k-1];
        rd_in[k]  = rd_out[k-1].valid ? rd_out[k-1] :
                    ((ctl_rd.valid && ctl_lvl == LW'(k)) ? ctl_rd : '0);
      end
    end else begin : g_rest
      always_comb begin
        tok_in[k] = tok_out[k-1];
        rd_in[k]  = rd_out[k-1].valid ? rd_out[k-1] :
                    ((ctl_rd.valid && ctl_lvl == LW'(k)) ? ctl_rd : '0);
      end
    end

    if (k == LEVELS - 1) begin : g_tail
      assign wb_in[k] = '0;
    end else begin : g_mid
      assign wb_in[k] = wb_out[k+1];
    end

    assign tok_vld[k] = tok_out[k].valid;

    mhpq_cell #(
      .LEVEL        (k),
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op_q),
      .tok_i   (tok_in[k]),
      .rd_i    (rd_in[k]),
      .wb_i    (wb_in[k]),
      .tok_o   (tok_out[k]),
      .rd_o    (rd_out[k]),
      .wb_o    (wb_out[k]),
      .rdata_o (rdata[k]),
      .done_o  (done[k])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (cmd == OP_PUSH) begin
            state_d = full ? ST_ROOT : ST_PREP;
          end else begin
            state_d = (count_q <= CW'(1)) ? ST_ROOT : ST_PREP;
          end
        end
      end
      ST_PREP:   state_d = (op_q.mode == OP_PUSH) ? ST_WALK : ST_LOAD;
      ST_LOAD:   state_d = ST_WALK;
      ST_WALK: begin
        if (|done) state_d = ST_ROOT;
      end
      ST_ROOT:   state_d = ST_RESULT;
      ST_RESULT: begin
        if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    ctl_rd   = '0;
    ctl_lvl  = '0;
    inj_d    = '0;
    out_load = 1'b0;
    case (state_q)
      ST_PREP: begin
        ctl_rd.valid = 1'b1;
        if (op_q.mode == OP_PUSH) begin
          inj_d.valid = 1'b1;
          inj_d.carry = x_q;
        end else begin
          ctl_lvl    = lastlvl_q;
          ctl_rd.row = POS_W'(lastpos_q >> 1);
        end
      end
      ST_LOAD: begin
        ctl_rd.valid = 1'b1;
        ctl_lvl      = LW'(1);
        inj_d.valid  = 1'b1;
        inj_d.carry  = lastpos_q[0] ? rdata[lastlvl_q].hi : rdata[lastlvl_q].lo;
      end
      ST_ROOT: begin
        ctl_rd.valid = 1'b1;
      end
      ST_RESULT: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (cmd == OP_PUSH && !full) begin
        count_d = n_inc;
      end else if (cmd == OP_POP && count_q != '0) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      inj_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      inj_q   <= inj_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q.mode  <= cmd;
      op_q.bound <= POS_W'(count_q - CW'(1));
      op_q.tgt1  <= POS_W'(n_inc);
      op_q.dlev  <= LVL_W'(top_bit(n_inc));
      x_q.prio    <= s_axis_tdata[63:32];
      x_q.payload <= PAY_W'(s_axis_tdata[PAYLOAD_BITS-1:0]);
      lastlvl_q  <= pop_lvl;
      lastpos_q  <= pop_pos;
      if (cmd == OP_PUSH) begin
        status_q <= full ? STAT_FULL : STAT_OK;
      end else begin
        status_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
      end
    end
    if (out_load) begin
      m_tdata_q[31:0]  <= (count_q != '0) ? rdata[0].lo.payload : '0;
      m_tdata_q[63:32] <= (count_q != '0) ? rdata[0].lo.prio : '0;
      m_tdata_q[70:64] <= COUNT_W'(count_q);
      m_tdata_q[71]    <= 1'b0;
      m_tuser_q[0]     <= (count_q != '0);
      m_tuser_q[2:1]   <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  a_chain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok_out[LEVELS-1].valid && !rd_out[LEVELS-1].valid && !wb_out[0].valid)
    else $error("request left the cell chain");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one token in the chain");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count beyond capacity");

  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|done) |-> (state_q == ST_WALK))
    else $error("sift finished outside the walk");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted request did not start");

endmodule

`default_nettype wire
